// ===== hw/rtl/hs_pkg.sv =====
`timescale 1ns / 1ps

package hs_pkg;

  // Default store depth and the width of one value.
  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;

  // Addresses of the microprogram.
  typedef enum logic [4:0] {
    S_LOAD  = 5'd0,
    S_BINIT = 5'd1,
    S_BNODE = 5'd2,
    S_VLOAD = 5'd3,
    S_RDL   = 5'd4,
    S_RDR   = 5'd5,
    S_GETL  = 5'd6,
    S_GETR  = 5'd7,
    S_MOVE  = 5'd8,
    S_WRV   = 5'd9,
    S_BNEXT = 5'd10,
    S_XINIT = 5'd11,
    S_XRD0  = 5'd12,
    S_XRDK  = 5'd13,
    S_XSWAP = 5'd14,
    S_XNEXT = 5'd15,
    S_OUTRD = 5'd16,
    S_OUTLD = 5'd17,
    S_FIN   = 5'd18
  } step_t;

  // Datapath operations, one per control word.
  typedef enum logic [4:0] {
    OP_LOAD,
    OP_BINIT,
    OP_BNODE,
    OP_VLOAD,
    OP_RDL,
    OP_RDR,
    OP_GETL,
    OP_GETR,
    OP_MOVE,
    OP_WRV,
    OP_NOP,
    OP_XINIT,
    OP_XRD0,
    OP_XRDK,
    OP_XSWAP,
    OP_OUTRD,
    OP_OUTLD,
    OP_FIN
  } op_t;

  // Jump conditions; a control word jumps to its target when its condition holds.
  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_IDLE,
    C_FEW,
    C_NO_LEFT,
    C_LESS,
    C_EXTRACT,
    C_K_NZ,
    C_K_GT1,
    C_OUT_STALL,
    C_MORE_OUT
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  // Flags from the datapath that the jump conditions test.
  typedef struct packed {
    logic idle;
    logic few;
    logic no_left;
    logic less;
    logic extract;
    logic k_nz;
    logic k_gt1;
    logic out_stall;
    logic more_out;
  } status_t;

  // Microprogram: load, heap build, extraction, emission.
  function automatic ucode_t hs_ucode(input step_t s);
    ucode_t w;
    unique case (s)
      S_LOAD:  w = '{op: OP_LOAD,  cond: C_IDLE,      target: S_LOAD};
      S_BINIT: w = '{op: OP_BINIT, cond: C_FEW,       target: S_XINIT};
      S_BNODE: w = '{op: OP_BNODE, cond: C_NONE,      target: S_LOAD};
      S_VLOAD: w = '{op: OP_VLOAD, cond: C_NONE,      target: S_LOAD};
      S_RDL:   w = '{op: OP_RDL,   cond: C_NO_LEFT,   target: S_WRV};
      S_RDR:   w = '{op: OP_RDR,   cond: C_NONE,      target: S_LOAD};
      S_GETL:  w = '{op: OP_GETL,  cond: C_NONE,      target: S_LOAD};
      S_GETR:  w = '{op: OP_GETR,  cond: C_NONE,      target: S_LOAD};
      S_MOVE:  w = '{op: OP_MOVE,  cond: C_LESS,      target: S_RDL};
      S_WRV:   w = '{op: OP_WRV,   cond: C_EXTRACT,   target: S_XNEXT};
      S_BNEXT: w = '{op: OP_NOP,   cond: C_K_NZ,      target: S_BNODE};
      S_XINIT: w = '{op: OP_XINIT, cond: C_FEW,       target: S_OUTRD};
      S_XRD0:  w = '{op: OP_XRD0,  cond: C_NONE,      target: S_LOAD};
      S_XRDK:  w = '{op: OP_XRDK,  cond: C_NONE,      target: S_LOAD};
      S_XSWAP: w = '{op: OP_XSWAP, cond: C_ALWAYS,    target: S_RDL};
      S_XNEXT: w = '{op: OP_NOP,   cond: C_K_GT1,     target: S_XRD0};
      S_OUTRD: w = '{op: OP_OUTRD, cond: C_OUT_STALL, target: S_OUTRD};
      S_OUTLD: w = '{op: OP_OUTLD, cond: C_MORE_OUT,  target: S_OUTRD};
      S_FIN:   w = '{op: OP_FIN,   cond: C_ALWAYS,    target: S_LOAD};
      default: w = '{op: OP_FIN,   cond: C_ALWAYS,    target: S_LOAD};
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/hs_seq.sv =====
`timescale 1ns / 1ps

module hs_seq (
  input  logic             clk,
  input  logic             rst,
  input  hs_pkg::status_t  status,
  output hs_pkg::ucode_t   ctrl
);

  hs_pkg::step_t step;
  hs_pkg::step_t step_next;
  logic          take;

  // Fetch the control word of the current step.
  assign ctrl = hs_pkg::hs_ucode(step);

  // Evaluate the jump condition.
  always_comb begin
    unique case (ctrl.cond)
      hs_pkg::C_NONE:      take = 1'b0;
      hs_pkg::C_ALWAYS:    take = 1'b1;
      hs_pkg::C_IDLE:      take = status.idle;
      hs_pkg::C_FEW:       take = status.few;
      hs_pkg::C_NO_LEFT:   take = status.no_left;
      hs_pkg::C_LESS:      take = status.less;
      hs_pkg::C_EXTRACT:   take = status.extract;
      hs_pkg::C_K_NZ:      take = status.k_nz;
      hs_pkg::C_K_GT1:     take = status.k_gt1;
      hs_pkg::C_OUT_STALL: take = status.out_stall;
      hs_pkg::C_MORE_OUT:  take = status.more_out;
      default:             take = 1'b0;
    endcase
    step_next = take ? ctrl.target : hs_pkg::step_t'(step + 5'd1);
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= hs_pkg::S_LOAD;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== hw/rtl/heap_sorter.sv =====
`timescale 1ns / 1ps

// Heap sorter. Values arrive one per beat on the s_axis channel; the beat with
// s_axis_tlast high closes the set and starts the sort. Values beyond the store
// depth are discarded and every result of that run carries m_axis_tuser high.
// Once sorted, the values leave on m_axis in ascending order, the final beat
// marked with m_axis_tlast, after which the block accepts a new set.
// While loading, s_axis_tready stays high and a beat is taken whenever
// s_axis_tvalid is high. The sort is a short microprogram over a store with
// one read port and one write port (one read and one write per cycle): it
// builds a max-heap by sift-down, then repeatedly swaps the root to the end
// of the heap and sifts down again; emission reads each value in turn and
// loads it into the output register. s_axis_tready stays low from the last
// beat until the final result has been loaded into the output register.
// A stalled receiver holds the output register and halts the microprogram at
// its emit step; nothing is lost. Reset empties the set and clears the output;
// the store contents are not cleared.
module heap_sorter #(
  parameter int CAPACITY = hs_pkg::CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // value[31:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // value_res[31:0]
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // dropped
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = hs_pkg::DATA_W;

  hs_pkg::ucode_t  ctrl;
  hs_pkg::status_t status;

  // Store and its ports.
  logic signed [DW-1:0] store [CAPACITY];
  logic signed [DW-1:0] rdata;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic signed [DW-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;

  // Control registers.
  logic [CW-1:0] count;
  logic          ovf;
  logic          pend;
  logic          extract;

  // Working registers.
  logic [CW-1:0]        size;
  logic [CW-1:0]        k;
  logic [CW-1:0]        j;
  logic [AW-1:0]        cur;
  logic [AW-1:0]        cidx;
  logic signed [DW-1:0] val;
  logic signed [DW-1:0] cval;

  // Derived values.
  logic [AW+1:0] l_ext;
  logic [AW+1:0] r_ext;
  logic [AW+1:0] size_ext;
  logic [CW-1:0] km1;
  logic [CW-1:0] j1;
  logic          in_fire;
  logic          room;
  logic          r_wins;
  logic          less;

  assign l_ext    = {1'b0, cur, 1'b1};
  assign r_ext    = {({1'b0, cur} + {{AW{1'b0}}, 1'b1}), 1'b0};
  assign size_ext = (AW + 2)'(size);
  assign km1      = k - CW'(1);
  assign j1       = j + CW'(1);
  assign room     = count < CW'(CAPACITY);
  assign less     = val < cval;
  assign r_wins   = (r_ext < size_ext) && (cval < rdata);

  assign s_axis_tready = (ctrl.op == hs_pkg::OP_LOAD) && !pend;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Flags for the sequencer.
  always_comb begin
    status.idle      = !pend;
    status.few       = count < CW'(2);
    status.no_left   = !(l_ext < size_ext);
    status.less      = less;
    status.extract   = extract;
    status.k_nz      = k != '0;
    status.k_gt1     = k > CW'(1);
    status.out_stall = m_axis_tvalid && !m_axis_tready;
    status.more_out  = j1 != count;
  end

  hs_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // Store address and data selection per operation. Read data is registered and
  // arrives in the step after its address, so the left child is addressed in the step
  // before its capture and the right child in the step that captures the left.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count[AW-1:0];
    mem_wdata = $signed(s_axis_tdata);
    mem_raddr = cur;
    unique case (ctrl.op)
      hs_pkg::OP_LOAD: begin
        mem_we = in_fire && room;
      end
      hs_pkg::OP_BNODE: begin
        mem_raddr = km1[AW-1:0];
      end
      hs_pkg::OP_RDR: begin
        mem_raddr = l_ext[AW-1:0];
      end
      hs_pkg::OP_GETL: begin
        mem_raddr = r_ext[AW-1:0];
      end
      hs_pkg::OP_MOVE: begin
        mem_we    = less;
        mem_waddr = cur;
        mem_wdata = cval;
      end
      hs_pkg::OP_WRV: begin
        mem_we    = 1'b1;
        mem_waddr = cur;
        mem_wdata = val;
      end
      hs_pkg::OP_XRD0: begin
        mem_raddr = '0;
      end
      hs_pkg::OP_XRDK: begin
        mem_raddr = km1[AW-1:0];
      end
      hs_pkg::OP_XSWAP: begin
        mem_we    = 1'b1;
        mem_waddr = km1[AW-1:0];
        mem_wdata = cval;
      end
      hs_pkg::OP_OUTRD: begin
        mem_raddr = j[AW-1:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Store with one read port and one write port, and registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    rdata <= store[mem_raddr];
  end

  // Control state: load count, overflow, pending sort, phase, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      ovf           <= 1'b0;
      pend          <= 1'b0;
      extract       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (in_fire) begin
        if (room) begin
          count <= count + CW'(1);
        end else begin
          ovf <= 1'b1;
        end
        if (s_axis_tlast) begin
          pend <= 1'b1;
        end
      end
      if (ctrl.op == hs_pkg::OP_BINIT) begin
        extract <= 1'b0;
      end
      if (ctrl.op == hs_pkg::OP_XINIT) begin
        extract <= 1'b1;
      end
      if (ctrl.op == hs_pkg::OP_FIN) begin
        count <= '0;
        ovf   <= 1'b0;
        pend  <= 1'b0;
      end
      if (ctrl.op == hs_pkg::OP_OUTLD) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Working registers and output payload.
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      hs_pkg::OP_BINIT: begin
        size <= count;
        k    <= count >> 1;
      end
      hs_pkg::OP_BNODE: begin
        cur <= km1[AW-1:0];
        k   <= km1;
      end
      hs_pkg::OP_VLOAD: begin
        val <= rdata;
      end
      hs_pkg::OP_GETL: begin
        cval <= rdata;
        cidx <= l_ext[AW-1:0];
      end
      hs_pkg::OP_GETR: begin
        if (r_wins) begin
          cval <= rdata;
          cidx <= r_ext[AW-1:0];
        end
      end
      hs_pkg::OP_MOVE: begin
        if (less) begin
          cur <= cidx;
        end
      end
      hs_pkg::OP_XINIT: begin
        k <= count;
        j <= '0;
      end
      hs_pkg::OP_XRDK: begin
        cval <= rdata;
      end
      hs_pkg::OP_XSWAP: begin
        val  <= rdata;
        cur  <= '0;
        size <= km1;
        k    <= km1;
      end
      hs_pkg::OP_OUTLD: begin
        m_axis_tdata <= rdata;
        m_axis_tlast <= !status.more_out;
        m_axis_tuser <= ovf;
        j            <= j1;
      end
      default: begin
        cur <= cur;
      end
    endcase
  end

  // The load count never passes the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("load count exceeds store depth");

  // A result is only loaded into a free output register.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == hs_pkg::OP_OUTLD) |-> !m_axis_tvalid)
    else $error("output register overwritten");

  // A child moved up during sift-down lies inside the heap.
  a_move_in_heap: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == hs_pkg::OP_MOVE && less) |-> (CW'(cidx) < size))
    else $error("sift-down moved an entry outside the heap");

  // No input beat is taken while a sort is under way.
  a_no_load_in_sort: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op != hs_pkg::OP_LOAD) |-> !s_axis_tready)
    else $error("input accepted during sort");

endmodule
